// ----- src/suffix_automaton_build_and_match_assert.svh -----
// Assertion macros for the suffix automaton block.
`ifndef SUFFIX_AUTOMATON_BUILD_AND_MATCH_ASSERT_SVH
`define SUFFIX_AUTOMATON_BUILD_AND_MATCH_ASSERT_SVH
`ifndef ASSERT_OFF
`define SAM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define SAM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define SAM_ASSERT(label, prop)
`define SAM_ASSERT_RST(label, prop)
`endif
`endif

// ----- src/sam_pkg.sv -----
// ----------------------------------------------------------------------------
// sam_pkg
// Shared sizes and action codes of the suffix automaton block.
// ----------------------------------------------------------------------------
`default_nettype none
package sam_pkg;
  localparam int unsigned MaxText  = 1024;
  localparam int unsigned Alphabet = 26;
  localparam int unsigned Nodes    = 2 * MaxText;
  localparam int unsigned NodeW    = $clog2(Nodes);
  localparam int unsigned CountW   = $clog2(Nodes + 1);
  localparam int unsigned LenW     = $clog2(MaxText + 1);
  localparam int unsigned SymW     = 5;
  localparam int unsigned SymIdxW  = $clog2(Alphabet);
  localparam int unsigned EdgeW    = NodeW + SymIdxW;

  localparam logic [1:0] ActReset   = 2'd0;
  localparam logic [1:0] ActAppend  = 2'd1;
  localparam logic [1:0] ActMatch   = 2'd2;
  localparam logic [1:0] ActRestart = 2'd3;

  // edge memory address: node times 32 plus symbol
  function automatic logic [EdgeW-1:0] edge_addr(logic [NodeW-1:0] n,
                                                 logic [SymIdxW-1:0] s);
    edge_addr = {n, s};
  endfunction

  typedef struct packed {
    logic             we;
    logic [EdgeW-1:0] waddr;
    logic [NodeW-1:0] wdata;
    logic [EdgeW-1:0] raddr;
  } edge_req_t;
endpackage
`default_nettype wire

// ----- src/sam_edge_mem.sv -----
// ----------------------------------------------------------------------------
// sam_edge_mem
// Transition memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sam_edge_mem import sam_pkg::*; (
  input  wire logic             clk_i,
  input  wire edge_req_t        req_i,
  output logic [NodeW-1:0]      rdata_o
);
  logic [NodeW-1:0] mem [2**EdgeW];
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end
endmodule
`default_nettype wire

// ----- src/sam_node_mem.sv -----
// ----------------------------------------------------------------------------
// sam_node_mem
// Per-node link and length memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module sam_node_mem import sam_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [NodeW-1:0] waddr_i,
  input  wire logic [NodeW-1:0] wlink_i,
  input  wire logic [LenW-1:0]  wlen_i,
  input  wire logic [NodeW-1:0] raddr_i,
  output logic [NodeW-1:0]      rlink_o,
  output logic [LenW-1:0]       rlen_o
);
  logic [NodeW+LenW-1:0] mem [Nodes];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wlink_i, wlen_i};
    end
    {rlink_o, rlen_o} <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/suffix_automaton_build_and_match.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_build_and_match
// Online suffix automaton builder and query matcher.
// ----------------------------------------------------------------------------
// Input words on s_axis carry action and symbol. Each word gives exactly one
// output word on m_axis with node count, walk state, match length and the
// overflow flag. A sequencer handles one word at a time. It works around two
// memories (transitions, link/length), each with a registered read.
// After the accepting edge, each word is worked off in these steps:
// restart, ignored or refused append, out-of-alphabet match: output only.
// match: walk the suffix-link chain until an edge is found or root fails.
// reset: clear the root row.
// append: clear the new row, then walk the suffix-link chain and add edges.
// If an existing edge is found, its target is read. A clone copies the
// row, makes 3 link/length writes and redirects the matching edges.
// s_axis_tready is high only while idle, so one word is in flight at a time.
// A new word is taken while a result waits in the output register. A stalled
// receiver holds that result and blocks the next result only.
// rst_ni puts the walk and counters at the root and then clears the root
// row with s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none
module suffix_automaton_build_and_match import sam_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // action[1:0], symbol[6:2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // node_total[11:0], match_node[22:12],
                                          // match_length[33:23], overflow[34]
);
  `include "suffix_automaton_build_and_match_assert.svh"

  localparam logic [3:0] SIdle  = 4'd0,  SClr   = 4'd1,  SAp0   = 4'd2,
                         SAp1   = 4'd3,  SAp2   = 4'd4,  SAp3   = 4'd5,
                         SCp0   = 4'd6,  SCp1   = 4'd7,  SCl0   = 4'd8,
                         SCl1   = 4'd9,  SCl2   = 4'd10, SRe0   = 4'd11,
                         SRe1   = 4'd12, SMt0   = 4'd13, SMt1   = 4'd14,
                         SOut   = 4'd15;

  logic [3:0]          st_q, st_d;
  logic [1:0]          act_q, act_d;
  logic [SymIdxW-1:0]  sym_q, sym_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic [NodeW-1:0]    last_q, last_d;
  logic [LenW-1:0]     tlen_q, tlen_d;
  logic [NodeW-1:0]    wn_q, wn_d;
  logic [LenW-1:0]     wl_q, wl_d;
  logic [NodeW-1:0]    cur_q, cur_d, p_q, p_d, q_q, q_d, cl_q, cl_d;
  logic [LenW-1:0]     plen_q, plen_d, clen_q, clen_d, qlen_q, qlen_d;
  logic [NodeW-1:0]    qlink_q, qlink_d;
  logic [SymIdxW-1:0]  idx_q, idx_d;
  logic                ovf_q, ovf_d;
  logic                ov_q, ov_d;
  logic                boot_q, boot_d;
  logic [39:0]         ob_q, ob_d;

  edge_req_t           er;
  logic [NodeW-1:0]    erd;
  logic                nwe;
  logic [NodeW-1:0]    nwa, nwl, nra, nrl;
  logic [LenW-1:0]     nwlen, nrlen;

  sam_edge_mem u_edge (.clk_i, .req_i(er), .rdata_o(erd));
  sam_node_mem u_node (.clk_i, .we_i(nwe), .waddr_i(nwa), .wlink_i(nwl),
                       .wlen_i(nwlen), .raddr_i(nra), .rlink_o(nrl), .rlen_o(nrlen));

  logic out_free;
  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (st_q == SIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ob_q;

  always_comb begin
    st_d = st_q; act_d = act_q; sym_d = sym_q; cnt_d = cnt_q; last_d = last_q;
    tlen_d = tlen_q; wn_d = wn_q; wl_d = wl_q; cur_d = cur_q; p_d = p_q;
    q_d = q_q; cl_d = cl_q; plen_d = plen_q; clen_d = clen_q; qlen_d = qlen_q;
    qlink_d = qlink_q; idx_d = idx_q; ovf_d = ovf_q; ob_d = ob_q; boot_d = boot_q;
    ov_d = ov_q && !m_axis_tready;
    er = '0; nwe = 1'b0; nwa = '0; nwl = '0; nwlen = '0; nra = '0;
    unique case (st_q)
      SIdle: begin
        if (s_axis_tvalid) begin
          act_d = s_axis_tdata[1:0];
          sym_d = s_axis_tdata[2 +: SymIdxW];
          ovf_d = 1'b0; idx_d = '0;
          unique case (s_axis_tdata[1:0])
            ActReset: begin
              cnt_d = CountW'(1); last_d = '0; tlen_d = '0; wn_d = '0; wl_d = '0;
              st_d = SClr;
            end
            ActAppend: begin
              if (s_axis_tdata[6:2] >= SymW'(Alphabet)) begin
                st_d = SOut;
              end else if (tlen_q >= LenW'(MaxText) ||
                           (cnt_q + CountW'(2)) > CountW'(Nodes)) begin
                ovf_d = 1'b1; st_d = SOut;
              end else begin
                cur_d = cnt_q[NodeW-1:0]; cnt_d = cnt_q + CountW'(1);
                p_d = last_q; last_d = cnt_q[NodeW-1:0]; tlen_d = tlen_q + LenW'(1);
                st_d = SClr;
              end
            end
            ActMatch: begin
              if (s_axis_tdata[6:2] >= SymW'(Alphabet)) begin
                wn_d = '0; wl_d = '0; st_d = SOut;
              end else begin
                p_d = wn_q; st_d = SMt0;
              end
            end
            default: begin
              wn_d = '0; wl_d = '0; st_d = SOut;
            end
          endcase
        end
      end
      SClr: begin
        // clear the row of the new node (or the root on reset);
        // meanwhile read the length of the previous last node
        er.we = 1'b1;
        er.waddr = edge_addr((act_q == ActReset) ? NodeW'(0) : cur_q, idx_q);
        nra = p_q;
        idx_d = idx_q + SymIdxW'(1);
        if (idx_q == SymIdxW'(Alphabet - 1)) begin
          idx_d = '0;
          if (act_q == ActReset) begin
            nwe = 1'b1;
            if (boot_q) begin
              boot_d = 1'b0; st_d = SIdle;
            end else begin
              st_d = SOut;
            end
          end else begin
            clen_d = nrlen + LenW'(1);
            st_d = SAp0;
          end
        end
      end
      SAp0: begin
        nra = p_q; er.raddr = edge_addr(p_q, sym_q); st_d = SAp1;
      end
      SAp1: begin
        plen_d = nrlen;
        if (erd != '0) begin
          q_d = erd; st_d = SAp2;
        end else begin
          er.we = 1'b1; er.waddr = edge_addr(p_q, sym_q); er.wdata = cur_q;
          if (p_q == '0) begin
            nwe = 1'b1; nwa = cur_q; nwl = '0; nwlen = clen_q;
            st_d = SOut;
          end else begin
            p_d = nrl; st_d = SAp0;
          end
        end
      end
      SAp2: begin
        nra = q_q; st_d = SAp3;
      end
      SAp3: begin
        qlen_d = nrlen; qlink_d = nrl;
        if (nrlen == plen_q + LenW'(1)) begin
          nwe = 1'b1; nwa = cur_q; nwl = q_q; nwlen = clen_q; st_d = SOut;
        end else begin
          cl_d = cnt_q[NodeW-1:0]; cnt_d = cnt_q + CountW'(1);
          idx_d = '0; st_d = SCp0;
        end
      end
      SCp0: begin
        er.raddr = edge_addr(q_q, idx_q); st_d = SCp1;
      end
      SCp1: begin
        er.we = 1'b1; er.waddr = edge_addr(cl_q, idx_q); er.wdata = erd;
        idx_d = idx_q + SymIdxW'(1);
        if (idx_q == SymIdxW'(Alphabet - 1)) begin
          idx_d = '0; st_d = SCl0;
        end else begin
          st_d = SCp0;
        end
      end
      SCl0: begin
        nwe = 1'b1; nwa = cl_q; nwl = qlink_q; nwlen = plen_q + LenW'(1);
        st_d = SCl1;
      end
      SCl1: begin
        // q keeps its own length and now links to the clone
        nwe = 1'b1; nwa = q_q; nwl = cl_q; nwlen = qlen_q; st_d = SCl2;
      end
      SCl2: begin
        nwe = 1'b1; nwa = cur_q; nwl = cl_q; nwlen = clen_q; st_d = SRe0;
      end
      SRe0: begin
        er.raddr = edge_addr(p_q, sym_q); nra = p_q; st_d = SRe1;
      end
      SRe1: begin
        if (erd != q_q) begin
          st_d = SOut;
        end else begin
          er.we = 1'b1; er.waddr = edge_addr(p_q, sym_q); er.wdata = cl_q;
          if (p_q == '0) begin
            st_d = SOut;
          end else begin
            p_d = nrl; st_d = SRe0;
          end
        end
      end
      SMt0: begin
        er.raddr = edge_addr(p_q, sym_q); nra = p_q; st_d = SMt1;
      end
      SMt1: begin
        if (erd != '0) begin
          wn_d = erd;
          wl_d = (p_q == wn_q) ? wl_q + LenW'(1) : nrlen + LenW'(1);
          st_d = SOut;
        end else if (p_q == '0) begin
          wn_d = '0; wl_d = '0; st_d = SOut;
        end else begin
          p_d = nrl; st_d = SMt0;
        end
      end
      SOut: begin
        if (out_free) begin
          ov_d = 1'b1;
          ob_d = {5'd0, ovf_q, wl_q, wn_q, cnt_q};
          st_d = SIdle;
        end
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; act_q <= ActReset; idx_q <= '0; boot_q <= 1'b1;
      cnt_q <= CountW'(1); last_q <= '0; tlen_q <= '0;
      wn_q <= '0; wl_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; act_q <= act_d; idx_q <= idx_d; boot_q <= boot_d;
      cnt_q <= cnt_d; last_q <= last_d; tlen_q <= tlen_d;
      wn_q <= wn_d; wl_q <= wl_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; cur_q <= cur_d; p_q <= p_d; q_q <= q_d;
    cl_q <= cl_d; plen_q <= plen_d; clen_q <= clen_d; qlen_q <= qlen_d;
    qlink_q <= qlink_d; ovf_q <= ovf_d; ob_q <= ob_d;
  end

  logic unused;
  assign unused = s_axis_tdata[7];

  `SAM_ASSERT(a_ready_idle, s_axis_tready |-> st_q == SIdle)
  `SAM_ASSERT(a_cnt_range, cnt_q >= CountW'(1) && cnt_q <= CountW'(Nodes))
  `SAM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
endmodule
`default_nettype wire

// ----- verif/suffix_automaton_build_and_match_tb.sv -----
// ----------------------------------------------------------------------------
// suffix_automaton_build_and_match_tb
// Streams build, match, restart and reset words into the suffix automaton.
// Every output word is checked field by field against an in-bench model of
// the automaton or a directed row's value. Stimulus: a short directed table,
// random builds and queries over small or full alphabets, a text-filling build.
// ----------------------------------------------------------------------------
`default_nettype none
module suffix_automaton_build_and_match_tb import sam_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 8_000_000;

  // highest field first, so bit 0 is the low end of the output word
  typedef struct packed {
    logic        overflow;
    logic [10:0] match_length;
    logic [10:0] match_node;
    logic [11:0] node_total;
  } sam_result_t;

  typedef struct {
    logic [1:0]  act;
    logic [4:0]  sym;
    bit          typed;
    sam_result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // action[1:0], symbol[6:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;       // node_total[11:0], match_node[22:12],
                                   // match_length[33:23], overflow[34]

  suffix_automaton_build_and_match u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // automaton mirror
  int unsigned goto_tbl [Nodes*Alphabet];
  int unsigned sfx_link [Nodes];
  int unsigned long_len [Nodes];
  int unsigned n_states, tail_state, text_len, walk_at, walk_len;

  sam_result_t pending_results[$];
  int unsigned tx_idle_pct, rx_idle_pct;
  int unsigned mismatches;
  int unsigned cycles;

  function automatic int unsigned goto_idx(int unsigned node, int unsigned s);
    return (node % Nodes) * Alphabet + s;
  endfunction

  function automatic void clear_goto(int unsigned node);
    for (int s = 0; s < Alphabet; s++) goto_tbl[node*Alphabet + s] = 0;
  endfunction

  function automatic void automaton_clear();
    n_states = 1; tail_state = 0; text_len = 0; walk_at = 0; walk_len = 0;
    clear_goto(0);
    sfx_link[0] = 0;
    long_len[0] = 0;
  endfunction

  function automatic bit automaton_extend(int unsigned s);
    int unsigned cur, p, q, cl;
    bit found;
    found = 0;
    if (s >= Alphabet) return 0;
    if (text_len >= MaxText || n_states + 2 > Nodes) return 1;
    cur = n_states++;
    clear_goto(cur);
    long_len[cur] = long_len[tail_state] + 1;
    p = tail_state;
    tail_state = cur;
    text_len++;
    forever begin
      if (goto_tbl[goto_idx(p, s)] != 0) begin
        found = 1;
        break;
      end
      goto_tbl[goto_idx(p, s)] = cur;
      if (p == 0) break;
      p = sfx_link[p];
    end
    if (!found) begin
      sfx_link[cur] = 0;
      return 0;
    end
    q = goto_tbl[goto_idx(p, s)];
    if (long_len[q] == long_len[p] + 1) begin
      sfx_link[cur] = q;
      return 0;
    end
    // split q: clone takes its row and link
    cl = n_states++;
    long_len[cl] = long_len[p] + 1;
    for (int k = 0; k < Alphabet; k++) goto_tbl[cl*Alphabet + k] = goto_tbl[q*Alphabet + k];
    sfx_link[cl] = sfx_link[q];
    sfx_link[q] = cl;
    sfx_link[cur] = cl;
    forever begin
      if (goto_tbl[goto_idx(p, s)] != q) break;
      goto_tbl[goto_idx(p, s)] = cl;
      if (p == 0) break;
      p = sfx_link[p];
    end
    return 0;
  endfunction

  function automatic void automaton_walk(int unsigned s);
    int unsigned p;
    if (s >= Alphabet) begin
      walk_at = 0; walk_len = 0;
      return;
    end
    if (goto_tbl[goto_idx(walk_at, s)] != 0) begin
      walk_len++;
      walk_at = goto_tbl[goto_idx(walk_at, s)];
      return;
    end
    p = walk_at;
    forever begin
      if (goto_tbl[goto_idx(p, s)] != 0) begin
        walk_len = long_len[p] + 1;
        walk_at = goto_tbl[goto_idx(p, s)];
        return;
      end
      if (p == 0) break;
      p = sfx_link[p];
    end
    walk_at = 0; walk_len = 0;
  endfunction

  function automatic sam_result_t automaton_step(logic [1:0] act, logic [4:0] sym);
    sam_result_t r;
    bit ovf;
    ovf = 0;
    case (act)
      ActReset:   automaton_clear();
      ActAppend:  ovf = automaton_extend(sym);
      ActMatch:   automaton_walk(sym);
      ActRestart: begin
        walk_at = 0; walk_len = 0;
      end
    endcase
    r.node_total   = n_states[11:0];
    r.match_node   = walk_at[10:0];
    r.match_length = walk_len[10:0];
    r.overflow     = ovf;
    return r;
  endfunction

  // hold the word until taken, then log what it must produce
  task automatic send_word(logic [1:0] act, logic [4:0] sym, bit typed = 0,
                           sam_result_t typed_res = '0);
    sam_result_t r;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, sym, act};
    do @(posedge clk_i); while (!s_axis_tready);
    r = automaton_step(act, sym);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic build_and_query(int unsigned letters, int unsigned n_app,
                                 int unsigned n_qry);
    for (int i = 0; i < n_app; i++)
      send_word(ActAppend, ($urandom_range(49) == 0) ? 5'($urandom_range(26, 31))
                                                      : 5'($urandom_range(letters - 1)));
    send_word(ActRestart, 5'($urandom_range(31)));
    for (int i = 0; i < n_qry; i++)
      send_word(ActMatch, ($urandom_range(29) == 0) ? 5'($urandom_range(26, 31))
                                                     : 5'($urandom_range(letters - 1)));
  endtask

  task automatic random_mix(int unsigned n_items);
    int unsigned sent, n_app, n_qry;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_word(ActReset, 5'($urandom_range(31)));
          sent++;
        end
        1, 2: begin
          // noise: any action, any symbol
          send_word(2'($urandom_range(3)), 5'($urandom_range(31)));
          sent++;
        end
        default: begin
          n_app = $urandom_range(1, 30);
          n_qry = $urandom_range(1, 30);
          build_and_query(($urandom_range(4) == 0) ? Alphabet : $urandom_range(1, 4),
                          n_app, n_qry);
          sent += n_app + n_qry + 1;
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    sam_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[34:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: nodes %0d/%0d node %0d/%0d len %0d/%0d ovf %0d/%0d (exp/act)",
                     want.node_total, got.node_total, want.match_node, got.match_node,
                     want.match_length, got.match_length, want.overflow, got.overflow);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  dir_row_t dir_rows[$];

  function automatic dir_row_t mk(logic [1:0] a, logic [4:0] s, bit t = 0,
                                  int unsigned nt = 0, int unsigned mn = 0,
                                  int unsigned ml = 0, bit ov = 0);
    dir_row_t d;
    d.act = a; d.sym = s; d.typed = t;
    d.res = '{node_total: 12'(nt), match_node: 11'(mn), match_length: 11'(ml),
              overflow: ov};
    return d;
  endfunction

  initial begin
    mismatches = 0; cycles = 0;
    tx_idle_pct = 0; rx_idle_pct = 0;
    automaton_clear();
    // the pin reset leaves the automaton at the root
    dir_rows = '{
      mk(ActReset, 5'd0, 1, 1, 0, 0, 0),
      mk(ActMatch, 5'd0, 1, 1, 0, 0, 0),
      mk(ActAppend, 5'd31, 1, 1, 0, 0, 0),
      mk(ActAppend, 5'd26, 1, 1, 0, 0, 0),
      mk(ActAppend, 5'd0, 1, 2, 0, 0, 0),
      mk(ActAppend, 5'd1), mk(ActAppend, 5'd0), mk(ActAppend, 5'd1),
      mk(ActAppend, 5'd1), mk(ActAppend, 5'd25), mk(ActAppend, 5'd0),
      mk(ActMatch, 5'd0), mk(ActMatch, 5'd1), mk(ActMatch, 5'd1),
      mk(ActAppend, 5'd1), mk(ActMatch, 5'd25), mk(ActMatch, 5'd2),
      mk(ActMatch, 5'd0), mk(ActMatch, 5'd31), mk(ActMatch, 5'd1),
      mk(ActRestart, 5'd31), mk(ActMatch, 5'd25), mk(ActReset, 5'd31, 1, 1, 0, 0, 0),
      mk(ActRestart, 5'd0, 1, 1, 0, 0, 0)
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 8; rx_idle_pct = 80;
    foreach (dir_rows[i]) send_word(dir_rows[i].act, dir_rows[i].sym,
                                    dir_rows[i].typed, dir_rows[i].res);
    random_mix(150);

    tx_idle_pct = 80; rx_idle_pct = 8;
    random_mix(150);

    tx_idle_pct = 0; rx_idle_pct = 0;
    // fill the text to its limit, then push past it
    send_word(ActReset, 5'd0);
    for (int i = 0; i < MaxText + 6; i++) send_word(ActAppend, 5'($urandom_range(2)));
    build_and_query(3, 0, 40);
    random_mix(60);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
